/* sv/vad_gate_with_preroll_unit_defines.svh */
// Assertion macros for the voice gate.
`ifndef VAD_GATE_WITH_PREROLL_UNIT_DEFINES_SVH
`define VAD_GATE_WITH_PREROLL_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define VGP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define VGP_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define VGP_ASSERT(label, clk, rst, prop, msg)
`define VGP_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

/* sv/vgp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package vgp_pkg;

   localparam int SAMPLE_W = 16;
   localparam int MAG_W    = 15;
   localparam int NOW_W    = 32;
   localparam int THR_W    = 16;
   localparam int DEB_W    = 16;
   localparam int HOLD_W   = 31;
   localparam int SLOT_W   = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   typedef logic [1:0] send_src_type;

   localparam send_src_type SRC_NONE    = 2'd0;
   localparam send_src_type SRC_LIVE    = 2'd1;
   localparam send_src_type SRC_PREROLL = 2'd2;
   localparam send_src_type SRC_BACKLOG = 2'd3;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_THRESHOLD = 2'd0;
   localparam csr_idx_type CSR_DEBOUNCE  = 2'd1;
   localparam csr_idx_type CSR_HOLD      = 2'd2;

   localparam logic [THR_W-1:0]  THRESHOLD_RESET = 16'd1000;
   localparam logic [DEB_W-1:0]  DEBOUNCE_RESET  = 16'd2;
   localparam logic [HOLD_W-1:0] HOLD_RESET      = 31'd4000;

   localparam logic [DEB_W-1:0] STREAK_MAX = 16'hFFFF;

endpackage

`default_nettype wire

/* sv/vad_gate_with_preroll_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "vad_gate_with_preroll_unit_defines.svh"

// Energy voice gate with debounce, silence hangover and pre-roll replay. One PCM
// sample is taken per clock while req_stall is low; its magnitude goes into a frame
// accumulator at once. The sample flagged frame_last closes the frame and produces
// exactly one result through three registers: frame capture, threshold product,
// then the voiced test and gate update into the result register. Frame ends may
// follow each other in every cycle; the accumulator's single add sets the rate of
// one sample per cycle. Each result carries slot commands for an external frame
// store (pre-roll ring and live backlog FIFO) and the gate state after that frame.
// Register reset values: voice threshold 1000, debounce 2 frames, hold 4000 ms.
// Configure only while idle.
module vad_gate_with_preroll_unit #(
   parameter int PREROLL_SLOTS     = 8,
   parameter int BACKLOG_SLOTS     = 8,
   parameter int MAX_FRAME_SAMPLES = 2048
) (
   input  wire                                 clock,
   input  wire                                 reset,

   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire  signed [vgp_pkg::SAMPLE_W-1:0] req_sample,
   input  wire                                 req_frame_last,
   input  wire         [vgp_pkg::NOW_W-1:0]    req_now_ms,
   input  wire                                 req_wake_event,

   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic                                rsp_store_preroll,
   output logic        [vgp_pkg::SLOT_W-1:0]   rsp_preroll_write_slot,
   output logic                                rsp_backlog_write,
   output logic        [vgp_pkg::SLOT_W-1:0]   rsp_backlog_write_slot,
   output vgp_pkg::send_src_type               rsp_send_source,
   output logic        [vgp_pkg::SLOT_W-1:0]   rsp_send_slot,
   output logic                                rsp_recording,
   output logic                                rsp_sleeping,
   output logic                                rsp_overflow,

   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  vgp_pkg::csr_idx_type          csr_index,
   input  wire         [vgp_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int CNT_W  = $clog2(MAX_FRAME_SAMPLES + 1);
   localparam int SUM_W  = CNT_W + vgp_pkg::MAG_W;
   localparam int PROD_W = CNT_W + vgp_pkg::THR_W;
   localparam int PP_W   = (PREROLL_SLOTS > 1) ? $clog2(PREROLL_SLOTS) : 1;
   localparam int BP_W   = (BACKLOG_SLOTS > 1) ? $clog2(BACKLOG_SLOTS) : 1;
   localparam int PF_W   = $clog2(PREROLL_SLOTS + 1);
   localparam int BF_W   = $clog2(BACKLOG_SLOTS + 1);
   localparam int RMAX   = (PREROLL_SLOTS < BACKLOG_SLOTS) ? PREROLL_SLOTS : BACKLOG_SLOTS;
   localparam int RP_W   = $clog2(RMAX + 1);

   logic [vgp_pkg::THR_W-1:0]  thr_ff;
   logic [vgp_pkg::DEB_W-1:0]  deb_ff;
   logic [vgp_pkg::HOLD_W-1:0] hold_ff;

   logic                       out_free;
   logic                       b_free;
   logic                       a_free;
   logic                       req_fire;
   logic [vgp_pkg::SAMPLE_W-1:0] raw;
   logic [vgp_pkg::SAMPLE_W-1:0] mag;
   logic                       take;
   logic [SUM_W-1:0]           sum_add;
   logic [CNT_W-1:0]           cnt_add;

   logic [SUM_W-1:0]           sum_ff;
   logic [CNT_W-1:0]           cnt_ff;

   logic                       a_v_ff;
   logic [SUM_W-1:0]           a_sum_ff;
   logic [CNT_W-1:0]           a_cnt_ff;
   logic [vgp_pkg::NOW_W-1:0]  a_now_ff;
   logic                       a_wake_ff;

   logic                       b_v_ff;
   logic [SUM_W-1:0]           b_sum_ff;
   logic [PROD_W-1:0]          b_prod_ff;
   logic [vgp_pkg::NOW_W-1:0]  b_now_ff;
   logic                       b_wake_ff;

   logic                       rec_ff, rec_in;
   logic                       slp_ff, slp_in;
   logic [vgp_pkg::DEB_W-1:0]  streak_ff, streak_in;
   logic [vgp_pkg::NOW_W-1:0]  lvt_ff, lvt_in;
   logic [PP_W-1:0]            pwp_ff, pwp_in;
   logic [PF_W-1:0]            pfill_ff, pfill_in;
   logic [PP_W-1:0]            rrp_ff, rrp_in;
   logic [RP_W-1:0]            pend_ff, pend_in;
   logic [BP_W-1:0]            brp_ff, brp_in;
   logic [BP_W-1:0]            bwp_ff, bwp_in;
   logic [BF_W-1:0]            bfill_ff, bfill_in;

   logic                       voiced;
   logic [vgp_pkg::NOW_W-1:0]  dt;
   logic [PF_W-1:0]            n_replay;
   logic [PP_W:0]              rstart;

   logic                       o_store;
   logic [vgp_pkg::SLOT_W-1:0] o_pslot;
   logic                       o_bw;
   logic [vgp_pkg::SLOT_W-1:0] o_bslot;
   vgp_pkg::send_src_type      o_src;
   logic [vgp_pkg::SLOT_W-1:0] o_sslot;
   logic                       o_ovf;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= vgp_pkg::THRESHOLD_RESET;
         deb_ff  <= vgp_pkg::DEBOUNCE_RESET;
         hold_ff <= vgp_pkg::HOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            vgp_pkg::CSR_THRESHOLD: thr_ff  <= csr_data[vgp_pkg::THR_W-1:0];
            vgp_pkg::CSR_DEBOUNCE:  deb_ff  <= csr_data[vgp_pkg::DEB_W-1:0];
            vgp_pkg::CSR_HOLD:      hold_ff <= csr_data[vgp_pkg::HOLD_W-1:0];
            default: ;
         endcase
      end
   end

   assign out_free  = !rsp_valid || !rsp_stall;
   assign b_free    = !b_v_ff || out_free;
   assign a_free    = !a_v_ff || b_free;
   assign req_stall = !a_free;
   assign req_fire  = req_valid && !req_stall;

   assign raw     = req_sample;
   assign mag     = raw[vgp_pkg::SAMPLE_W-1] ? (~raw + 16'd1) : raw;
   assign take    = cnt_ff < CNT_W'(MAX_FRAME_SAMPLES);
   assign sum_add = take ? (sum_ff + SUM_W'(mag)) : sum_ff;
   assign cnt_add = take ? (cnt_ff + CNT_W'(1)) : cnt_ff;

   // accumulate; close the frame on the flagged sample
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         cnt_ff <= '0;
      end else if (req_fire) begin
         if (req_frame_last) begin
            sum_ff <= '0;
            cnt_ff <= '0;
         end else begin
            sum_ff <= sum_add;
            cnt_ff <= cnt_add;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (a_free) begin
         a_v_ff <= req_fire && req_frame_last;
      end
   end

   always_ff @(posedge clock) begin
      if (a_free) begin
         a_sum_ff  <= sum_add;
         a_cnt_ff  <= cnt_add;
         a_now_ff  <= req_now_ms;
         a_wake_ff <= req_wake_event;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (b_free) begin
         b_v_ff <= a_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_free) begin
         b_sum_ff  <= a_sum_ff;
         b_prod_ff <= PROD_W'(thr_ff) * PROD_W'(a_cnt_ff);
         b_now_ff  <= a_now_ff;
         b_wake_ff <= a_wake_ff;
      end
   end

   assign voiced   = PROD_W'(b_sum_ff) >= b_prod_ff;
   assign dt       = b_now_ff - lvt_ff;
   assign n_replay = (pfill_ff > PF_W'(RMAX)) ? PF_W'(RMAX) : pfill_ff;
   assign rstart   = {1'b0, pwp_ff} + (PP_W + 1)'(PREROLL_SLOTS) - (PP_W + 1)'(n_replay);

   always_comb begin
      rec_in    = rec_ff;
      slp_in    = slp_ff;
      streak_in = streak_ff;
      lvt_in    = lvt_ff;
      pwp_in    = pwp_ff;
      pfill_in  = pfill_ff;
      rrp_in    = rrp_ff;
      pend_in   = pend_ff;
      brp_in    = brp_ff;
      bwp_in    = bwp_ff;
      bfill_in  = bfill_ff;
      o_store   = 1'b0;
      o_pslot   = '0;
      o_bw      = 1'b0;
      o_bslot   = '0;
      o_src     = vgp_pkg::SRC_NONE;
      o_sslot   = '0;
      o_ovf     = 1'b0;

      if (b_wake_ff) begin
         streak_in = '0;
         lvt_in    = b_now_ff;
         rec_in    = 1'b0;
      end

      if (voiced) begin
         lvt_in = b_now_ff;
         if (!rec_in) begin
            if (streak_in != vgp_pkg::STREAK_MAX) begin
               streak_in = streak_in + 16'd1;
            end
            if (streak_in >= deb_ff) begin
               if (pfill_ff != '0) begin
                  rrp_in   = (rstart >= (PP_W + 1)'(PREROLL_SLOTS))
                           ? PP_W'(rstart - (PP_W + 1)'(PREROLL_SLOTS)) : PP_W'(rstart);
                  pend_in  = RP_W'(n_replay);
                  pwp_in   = '0;
                  pfill_in = '0;
               end
               rec_in = 1'b1;
               slp_in = 1'b0;
            end
         end
      end else begin
         streak_in = '0;
         if (rec_in && !dt[vgp_pkg::NOW_W-1] && (dt[vgp_pkg::HOLD_W-1:0] >= hold_ff)) begin
            rec_in   = 1'b0;
            slp_in   = 1'b1;
            pwp_in   = '0;
            pfill_in = '0;
            rrp_in   = '0;
            pend_in  = '0;
            brp_in   = '0;
            bwp_in   = '0;
            bfill_in = '0;
         end
      end

      if (!rec_in) begin
         o_store = 1'b1;
         o_pslot = vgp_pkg::SLOT_W'(pwp_in);
         pwp_in  = (pwp_in == PP_W'(PREROLL_SLOTS - 1)) ? '0 : pwp_in + PP_W'(1);
         if (pfill_in < PF_W'(PREROLL_SLOTS)) begin
            pfill_in = pfill_in + PF_W'(1);
         end
      end else if (pend_in != '0) begin
         if (bfill_in >= BF_W'(BACKLOG_SLOTS)) begin
            o_ovf = 1'b1;
         end else begin
            o_bw     = 1'b1;
            o_bslot  = vgp_pkg::SLOT_W'(bwp_in);
            bwp_in   = (bwp_in == BP_W'(BACKLOG_SLOTS - 1)) ? '0 : bwp_in + BP_W'(1);
            bfill_in = bfill_in + BF_W'(1);
            o_src    = vgp_pkg::SRC_PREROLL;
            o_sslot  = vgp_pkg::SLOT_W'(rrp_in);
            rrp_in   = (rrp_in == PP_W'(PREROLL_SLOTS - 1)) ? '0 : rrp_in + PP_W'(1);
            pend_in  = pend_in - RP_W'(1);
         end
      end else if (bfill_in != '0) begin
         // drain one, then push the live frame into the freed place
         o_src   = vgp_pkg::SRC_BACKLOG;
         o_sslot = vgp_pkg::SLOT_W'(brp_in);
         brp_in  = (brp_in == BP_W'(BACKLOG_SLOTS - 1)) ? '0 : brp_in + BP_W'(1);
         o_bw    = 1'b1;
         o_bslot = vgp_pkg::SLOT_W'(bwp_in);
         bwp_in  = (bwp_in == BP_W'(BACKLOG_SLOTS - 1)) ? '0 : bwp_in + BP_W'(1);
      end else begin
         o_src = vgp_pkg::SRC_LIVE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff    <= 1'b0;
         slp_ff    <= 1'b0;
         streak_ff <= '0;
         lvt_ff    <= '0;
         pwp_ff    <= '0;
         pfill_ff  <= '0;
         rrp_ff    <= '0;
         pend_ff   <= '0;
         brp_ff    <= '0;
         bwp_ff    <= '0;
         bfill_ff  <= '0;
      end else if (out_free && b_v_ff) begin
         rec_ff    <= rec_in;
         slp_ff    <= slp_in;
         streak_ff <= streak_in;
         lvt_ff    <= lvt_in;
         pwp_ff    <= pwp_in;
         pfill_ff  <= pfill_in;
         rrp_ff    <= rrp_in;
         pend_ff   <= pend_in;
         brp_ff    <= brp_in;
         bwp_ff    <= bwp_in;
         bfill_ff  <= bfill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (out_free) begin
         rsp_valid <= b_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && b_v_ff) begin
         rsp_store_preroll      <= o_store;
         rsp_preroll_write_slot <= o_pslot;
         rsp_backlog_write      <= o_bw;
         rsp_backlog_write_slot <= o_bslot;
         rsp_send_source        <= o_src;
         rsp_send_slot          <= o_sslot;
         rsp_recording          <= rec_in;
         rsp_sleeping           <= slp_in;
         rsp_overflow           <= o_ovf;
      end
   end

   `VGP_ASSERT_NEVER(a_bfill_bound, clock, reset, bfill_ff > BF_W'(BACKLOG_SLOTS), "backlog fill beyond depth")
   `VGP_ASSERT_NEVER(a_rec_slp, clock, reset, rec_ff && slp_ff, "recording and sleeping at once")
   `VGP_ASSERT(a_rec_no_preroll, clock, reset, rec_ff |-> (pfill_ff == '0), "pre-roll filled while recording")
   `VGP_ASSERT(a_replay_pushes, clock, reset, (rsp_valid && (rsp_send_source == vgp_pkg::SRC_PREROLL)) |-> rsp_backlog_write, "replay without backlog write")

endmodule

`default_nettype wire
